### rtl/core/lsut_pkg.sv
// lsut_pkg: shared sizes, codes and types of the led strand unpack and transpose block
// used by lsut_front, lsut_fifo, lsut_back and led_strand_unpack_and_bit_transpose
// no dependencies
`default_nettype none

package lsut_pkg;

  // strand store geometry
  localparam int NUM_STRANDS  = 16;
  localparam int STRAND_BYTES = 2048;
  localparam int STRAND_W     = (NUM_STRANDS > 1) ? $clog2(NUM_STRANDS) : 1;
  localparam int LEN_W        = $clog2(STRAND_BYTES + 1);
  localparam int STORE_DEPTH  = NUM_STRANDS * STRAND_BYTES;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  // fixed field widths
  localparam int SEL_W   = 4;
  localparam int IDX_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int LANES   = 8;

  // job queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // packet command characters and start marker
  localparam logic [7:0] CHAR_BEGIN  = 8'h42;
  localparam logic [7:0] CHAR_END    = 8'h45;
  localparam logic [7:0] CHAR_STRAND = 8'h53;
  localparam logic [7:0] CHAR_START  = 8'h2A;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;

  // configuration register indexes
  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LAST  = 1'b1;

  // packet header parser state
  typedef enum logic [2:0] {
    HDR_CMD,
    HDR_STRAND,
    HDR_LEN_LO,
    HDR_LEN_HI,
    HDR_PAYLOAD,
    HDR_SKIP
  } hdr_state_t;

  // back end sequencer state
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_t;

  // job opcodes
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_BEGIN,
    OP_END,
    OP_ASM
  } op_t;

  // one queued job
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;    // store write address or first lane read address
    logic [7:0]        data;    // store write data
    logic [LANES-1:0]  mask;    // lanes that contribute bits
    logic              marker;  // emit start marker first
  } job_t;

endpackage

`default_nettype wire

### rtl/core/lsut_fifo.sv
// lsut_fifo: short job queue between the packet front end and the store back end
// depends on lsut_pkg (job_t, FIFO_DEPTH)
`default_nettype none

module lsut_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lsut_pkg::job_t push_job,
  input  wire logic          pop,
  output lsut_pkg::job_t     head,
  output logic               full,
  output logic               empty
);

  lsut_pkg::job_t                     slot_r [lsut_pkg::FIFO_DEPTH];
  logic [lsut_pkg::FIFO_PTR_W-1:0]    wr_ptr_r;
  logic [lsut_pkg::FIFO_PTR_W-1:0]    rd_ptr_r;
  logic [lsut_pkg::FIFO_PTR_W:0]      count_r;

  // status
  assign full  = (count_r == (lsut_pkg::FIFO_PTR_W + 1)'(lsut_pkg::FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire

### rtl/core/lsut_front.sv
// lsut_front: accepts input beats, parses packet headers, holds strand lengths and
// configuration, and turns each beat into at most one queued job
// depends on lsut_pkg
`default_nettype none

module lsut_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input beat fields
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic                          action,
  input  wire logic [7:0]                    byte_value,
  input  wire logic                          packet_end,
  input  wire logic [lsut_pkg::IDX_W-1:0]    pixel_index,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [lsut_pkg::SEL_W-1:0]    cfg_data,
  // job queue
  input  wire logic                          q_full,
  output logic                               push,
  output lsut_pkg::job_t                     push_job
);

  lsut_pkg::hdr_state_t               hdr_r, hdr_nxt;
  logic [lsut_pkg::SEL_W-1:0]         first_r, last_r;
  logic [7:0]                         target_r, target_nxt;
  logic [15:0]                        plen_r, plen_nxt;
  logic [15:0]                        pos_r, pos_nxt;
  logic [1:0]                         phase_r, phase_nxt;
  logic [lsut_pkg::LEN_W-1:0]         len_r [lsut_pkg::NUM_STRANDS];
  logic                               len_we;
  logic [lsut_pkg::LEN_W-1:0]         len_val;
  logic                               in_acc;
  logic                               accepted;
  logic [16:0]                        pos_inc;
  logic [15:0]                        dest;
  logic                               dest_ok;
  logic [lsut_pkg::ADDR_W-1:0]        wr_addr;
  logic [lsut_pkg::ADDR_W-1:0]        base_addr;
  logic [lsut_pkg::NUM_STRANDS-1:0]   idx_lt;
  logic [lsut_pkg::LANES-1:0]         lane_mask;
  logic [15:0]                        new_len;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // strand range check, taken when the length high byte arrives
  assign accepted = ({4'b0, first_r} <= target_r) && (target_r <= {4'b0, last_r}) &&
                    (9'(target_r) < 9'(lsut_pkg::NUM_STRANDS));
  assign new_len  = {byte_value, plen_r[7:0]};
  assign len_val  = (17'(new_len) < 17'(lsut_pkg::STRAND_BYTES)) ?
                    lsut_pkg::LEN_W'(new_len) : lsut_pkg::LEN_W'(lsut_pkg::STRAND_BYTES);

  // destination inside the strand: swap bytes 0 and 1 of each triple
  assign pos_inc = 17'(pos_r) + 17'd1;
  always_comb begin
    case (phase_r)
      2'd0:    dest = (pos_inc < 17'(plen_r)) ? pos_inc[15:0] : pos_r;
      2'd1:    dest = pos_r - 16'd1;
      default: dest = pos_r;
    endcase
  end
  assign dest_ok = (17'(dest) < 17'(lsut_pkg::STRAND_BYTES));
  assign wr_addr = lsut_pkg::ADDR_W'(int'(target_r[lsut_pkg::STRAND_W-1:0]) *
                   lsut_pkg::STRAND_BYTES + int'(dest));

  // per strand length check and lane mask for an assemble beat
  always_comb begin
    for (int t = 0; t < lsut_pkg::NUM_STRANDS; t++) begin
      idx_lt[t] = (17'(pixel_index) < 17'(len_r[t]));
    end
    lane_mask = '0;
    for (int s = 0; s < lsut_pkg::LANES; s++) begin
      for (int t = 0; t < lsut_pkg::NUM_STRANDS; t++) begin
        if ((int'(first_r) + s == t) && (t <= int'(last_r))) begin
          lane_mask[s] = idx_lt[t];
        end
      end
    end
  end
  assign base_addr = lsut_pkg::ADDR_W'(int'(first_r) * lsut_pkg::STRAND_BYTES +
                     int'(pixel_index));

  // header parser next state
  always_comb begin
    hdr_nxt = hdr_r;
    if (in_acc && !action) begin
      case (hdr_r)
        lsut_pkg::HDR_CMD: begin
          if (byte_value == lsut_pkg::CHAR_STRAND) begin
            hdr_nxt = lsut_pkg::HDR_STRAND;
          end else begin
            hdr_nxt = lsut_pkg::HDR_SKIP;
          end
        end
        lsut_pkg::HDR_STRAND:  hdr_nxt = lsut_pkg::HDR_LEN_LO;
        lsut_pkg::HDR_LEN_LO:  hdr_nxt = lsut_pkg::HDR_LEN_HI;
        lsut_pkg::HDR_LEN_HI:  hdr_nxt = accepted ? lsut_pkg::HDR_PAYLOAD : lsut_pkg::HDR_SKIP;
        lsut_pkg::HDR_PAYLOAD: hdr_nxt = lsut_pkg::HDR_PAYLOAD;
        default:               hdr_nxt = lsut_pkg::HDR_SKIP;
      endcase
      if (packet_end) begin
        hdr_nxt = lsut_pkg::HDR_CMD;
      end
    end
  end

  // header parser outputs and job build
  always_comb begin
    push       = 1'b0;
    push_job   = '0;
    target_nxt = target_r;
    plen_nxt   = plen_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    len_we     = 1'b0;
    if (in_acc && action) begin
      push            = 1'b1;
      push_job.op     = lsut_pkg::OP_ASM;
      push_job.addr   = base_addr;
      push_job.mask   = lane_mask;
      push_job.marker = (pixel_index == '0);
    end else if (in_acc) begin
      case (hdr_r)
        lsut_pkg::HDR_CMD: begin
          if (byte_value == lsut_pkg::CHAR_BEGIN) begin
            push        = 1'b1;
            push_job.op = lsut_pkg::OP_BEGIN;
          end else if (byte_value == lsut_pkg::CHAR_END) begin
            push        = 1'b1;
            push_job.op = lsut_pkg::OP_END;
          end
        end
        lsut_pkg::HDR_STRAND: begin
          target_nxt = byte_value;
        end
        lsut_pkg::HDR_LEN_LO: begin
          plen_nxt = {8'h00, byte_value};
        end
        lsut_pkg::HDR_LEN_HI: begin
          plen_nxt  = new_len;
          pos_nxt   = '0;
          phase_nxt = 2'd0;
          len_we    = accepted;
        end
        lsut_pkg::HDR_PAYLOAD: begin
          if (pos_r < plen_r) begin
            if (dest_ok) begin
              push          = 1'b1;
              push_job.op   = lsut_pkg::OP_WRITE;
              push_job.addr = wr_addr;
              push_job.data = byte_value;
            end
            pos_nxt   = pos_r + 16'd1;
            phase_nxt = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // parser registers and strand lengths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r    <= lsut_pkg::HDR_CMD;
      target_r <= '0;
      plen_r   <= '0;
      pos_r    <= '0;
      phase_r  <= '0;
      for (int t = 0; t < lsut_pkg::NUM_STRANDS; t++) begin
        len_r[t] <= '0;
      end
    end else begin
      hdr_r    <= hdr_nxt;
      target_r <= target_nxt;
      plen_r   <= plen_nxt;
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      if (len_we) begin
        len_r[target_r[lsut_pkg::STRAND_W-1:0]] <= len_val;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 4'd0;
      last_r  <= 4'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsut_pkg::REG_FIRST: first_r <= cfg_data;
        lsut_pkg::REG_LAST:  last_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/lsut_back.sv
// lsut_back: carries out queued jobs: strand store writes, frame events and
// the eight lane read plus bit-plane transpose of an assemble job
// depends on lsut_pkg
`default_nettype none

module lsut_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // job queue
  input  wire lsut_pkg::job_t                head,
  input  wire logic                          q_empty,
  output logic                               pop,
  // result beat
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [lsut_pkg::KIND_W-1:0]        out_kind,
  output logic [7:0]                         out_byte,
  output logic                               out_last
);

  lsut_pkg::back_state_t         state_r, state_nxt;
  logic [7:0]                    mem [lsut_pkg::STORE_DEPTH];
  logic [7:0]                    rdata_r;
  logic [lsut_pkg::ADDR_W-1:0]   addr_r;
  logic [lsut_pkg::LANES-1:0]    mask_r;
  logic                          marker_r;
  logic [3:0]                    cnt_r;
  logic [3:0]                    em_r;
  logic [7:0]                    plane_r [lsut_pkg::LANES];
  logic                          out_valid_r;
  logic [lsut_pkg::KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_free;
  logic                          out_load;
  logic                          mem_we;
  logic [2:0]                    plane_b;
  logic [7:0]                    tbyte;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  // bit-plane byte: bit s is bit 7-b of lane s
  assign plane_b = 3'(em_r - 4'd1);
  always_comb begin
    for (int s = 0; s < lsut_pkg::LANES; s++) begin
      tbyte[s] = plane_r[s][3'd7 - plane_b];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lsut_pkg::BK_IDLE: begin
        if (!q_empty && head.op == lsut_pkg::OP_ASM) begin
          state_nxt = lsut_pkg::BK_READ;
        end
      end
      lsut_pkg::BK_READ: begin
        if (cnt_r == 4'd8) begin
          state_nxt = lsut_pkg::BK_EMIT;
        end
      end
      lsut_pkg::BK_EMIT: begin
        if (out_free && em_r == 4'd8) begin
          state_nxt = lsut_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lsut_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop          = 1'b0;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    out_kind_nxt = lsut_pkg::KIND_DATA;
    out_byte_nxt = 8'h00;
    out_last_nxt = 1'b0;
    case (state_r)
      lsut_pkg::BK_IDLE: begin
        if (!q_empty) begin
          case (head.op)
            lsut_pkg::OP_WRITE: begin
              pop    = 1'b1;
              mem_we = 1'b1;
            end
            lsut_pkg::OP_BEGIN, lsut_pkg::OP_END: begin
              if (out_free) begin
                pop          = 1'b1;
                out_load     = 1'b1;
                out_kind_nxt = (head.op == lsut_pkg::OP_BEGIN) ? lsut_pkg::KIND_BEGIN :
                                                                  lsut_pkg::KIND_END;
                out_last_nxt = 1'b1;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      lsut_pkg::BK_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_byte_nxt = (em_r == 4'd0) ? lsut_pkg::CHAR_START : tbyte;
          out_last_nxt = (em_r == 4'd8);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsut_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      em_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        lsut_pkg::BK_IDLE: begin
          cnt_r <= '0;
          em_r  <= head.marker ? 4'd0 : 4'd1;
        end
        lsut_pkg::BK_READ: begin
          cnt_r <= cnt_r + 4'd1;
        end
        lsut_pkg::BK_EMIT: begin
          if (out_load) begin
            em_r <= em_r + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // lane read address, lane capture and result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_last_r <= out_last_nxt;
    end
    case (state_r)
      lsut_pkg::BK_IDLE: begin
        addr_r   <= head.addr;
        mask_r   <= head.mask;
        marker_r <= head.marker;
      end
      lsut_pkg::BK_READ: begin
        addr_r <= addr_r + lsut_pkg::ADDR_W'(lsut_pkg::STRAND_BYTES);
        if (cnt_r != 4'd0) begin
          plane_r[3'(cnt_r - 4'd1)] <= mask_r[3'(cnt_r - 4'd1)] ? rdata_r : 8'h00;
        end
      end
      default: begin
      end
    endcase
  end

  // strand store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.addr] <= head.data;
    end
    rdata_r <= mem[addr_r];
  end

`ifndef SYNTHESIS
  a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != lsut_pkg::BK_IDLE) |-> !pop)
    else $error("job taken while an assemble is in progress");
  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != lsut_pkg::KIND_DATA) |-> out_last_r)
    else $error("frame event beat without last flag");
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsut_pkg::BK_EMIT) |->
      (em_r <= 4'd8 && cnt_r == 4'd9 && (marker_r || em_r != 4'd0)))
    else $error("emit counter out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/led_strand_unpack_and_bit_transpose.sv
// Packet bytes and assemble requests enter on the in_ stream; results leave on the out_
// stream, each result beat one frame event or one byte, tlast on the last beat of an
// input. The front end turns a packet byte into a queued job and the back end takes a store
// write from the job queue, so packet streams run at one beat per cycle while the job queue
// is not full. An assemble request reads eight lanes from the single-port strand store one
// per cycle, then sends eight or nine result beats through the one-beat output register;
// it is dequeued, its lanes are read, then its beats are sent. A four-entry job queue lets
// packet bytes be taken while an assemble is being sent. The strand store itself is not
// cleared by reset; a strand reads as zero beyond its stored length.
// depends on lsut_pkg, lsut_front, lsut_fifo, lsut_back
`default_nettype none

module led_strand_unpack_and_bit_transpose (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] byte_value, [18:8] pixel_index, rest zero
  input  wire logic [0:0]  in_tuser,   // [0] action
  input  wire logic        in_tlast,   // packet_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,  // run_last
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data
);

  lsut_pkg::job_t push_job;
  lsut_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // packet parser and configuration
  lsut_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .action      (in_tuser[0]),
    .byte_value  (in_tdata[7:0]),
    .packet_end  (in_tlast),
    .pixel_index (in_tdata[18:8]),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  // job queue
  lsut_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // store and transpose
  lsut_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for led_strand_unpack_and_bit_transpose
// streams packet and assemble beats, predicts every result beat from its own strand model
// depends on lsut_pkg and the led_strand_unpack_and_bit_transpose rtl

module tb_top;

  localparam int SETTLE_CYCLES = 40;
  localparam int MISS_LIMIT    = 4000;
  localparam int HOLD_AT_BEAT  = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 10;
  localparam int PHASE_BEATS   = 28;

  typedef struct packed {
    logic        asm_req;
    logic [7:0]  bval;
    logic        pend;
    logic [10:0] pidx;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] byte_value, [18:8] pixel_index, rest zero
  logic [0:0]  in_tuser = '0;   // [0] action
  logic        in_tlast = 1'b0; // packet_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  logic [1:0]  out_tuser;       // [1:0] kind
  logic        out_tlast;       // run_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = lsut_pkg::REG_FIRST;
  logic [3:0]  cfg_data = '0;

  led_strand_unpack_and_bit_transpose dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // strand model: selection registers, header parser, store and stored lengths
  logic [3:0]           sel_first = 4'd0;
  logic [3:0]           sel_last = 4'd7;
  lsut_pkg::hdr_state_t parse_pos = lsut_pkg::HDR_CMD;
  logic [7:0]           pkt_strand = '0;
  int unsigned          pkt_len = 0;
  int unsigned          pkt_pos = 0;
  bit [7:0]             strand_mem [lsut_pkg::NUM_STRANDS*lsut_pkg::STRAND_BYTES];
  int unsigned          strand_len [lsut_pkg::NUM_STRANDS];

  // stimulus side view: stored length and the prefix known to be written
  int unsigned len_seen [lsut_pkg::NUM_STRANDS];
  int unsigned filled_upto [lsut_pkg::NUM_STRANDS];

  in_beat_t    pending [$];
  out_beat_t   planned [$];
  in_beat_t    in_cur;
  bit          in_taken = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned hold_left = 0;
  int unsigned in_gap_max = 8;
  int unsigned out_gap_max = 8;
  int unsigned beats_seen = 0;
  int unsigned queued = 0;
  int unsigned errors = 0;

  function automatic bit strand_in_range(input int unsigned s);
    return s >= sel_first && s <= sel_last && s < lsut_pkg::NUM_STRANDS;
  endfunction

  // result beats caused by one input beat, in order, tlast on the final one
  function automatic void predict_beats(input in_beat_t it);
    out_beat_t   run [$];
    out_beat_t   ob;
    logic [7:0]  plane;
    int unsigned st;
    int unsigned dest;
    if (it.asm_req) begin
      if (it.pidx == 0)
        run.push_back(out_beat_t'{lsut_pkg::KIND_DATA, lsut_pkg::CHAR_START, 1'b0});
      for (int b = 0; b < 8; b++) begin
        plane = '0;
        for (int s = 0; s < lsut_pkg::LANES; s++) begin
          st = sel_first + s;
          if (st <= sel_last && st < lsut_pkg::NUM_STRANDS && it.pidx < strand_len[st])
            plane[s] = strand_mem[st * lsut_pkg::STRAND_BYTES + it.pidx][7 - b];
        end
        run.push_back(out_beat_t'{lsut_pkg::KIND_DATA, plane, 1'b0});
      end
    end else begin
      case (parse_pos)
        lsut_pkg::HDR_CMD: begin
          if (it.bval == lsut_pkg::CHAR_BEGIN) begin
            run.push_back(out_beat_t'{lsut_pkg::KIND_BEGIN, 8'h00, 1'b0});
            parse_pos = lsut_pkg::HDR_SKIP;
          end else if (it.bval == lsut_pkg::CHAR_END) begin
            run.push_back(out_beat_t'{lsut_pkg::KIND_END, 8'h00, 1'b0});
            parse_pos = lsut_pkg::HDR_SKIP;
          end else if (it.bval == lsut_pkg::CHAR_STRAND) begin
            parse_pos = lsut_pkg::HDR_STRAND;
          end else begin
            parse_pos = lsut_pkg::HDR_SKIP;
          end
        end
        lsut_pkg::HDR_STRAND: begin
          pkt_strand = it.bval;
          parse_pos = lsut_pkg::HDR_LEN_LO;
        end
        lsut_pkg::HDR_LEN_LO: begin
          pkt_len = it.bval;
          parse_pos = lsut_pkg::HDR_LEN_HI;
        end
        lsut_pkg::HDR_LEN_HI: begin
          pkt_len = (int'(it.bval) << 8) | (pkt_len & 32'hFF);
          pkt_pos = 0;
          if (strand_in_range(pkt_strand)) begin
            strand_len[pkt_strand] = (pkt_len < lsut_pkg::STRAND_BYTES) ?
                                     pkt_len : lsut_pkg::STRAND_BYTES;
            parse_pos = lsut_pkg::HDR_PAYLOAD;
          end else begin
            parse_pos = lsut_pkg::HDR_SKIP;
          end
        end
        lsut_pkg::HDR_PAYLOAD: begin
          if (pkt_pos < pkt_len) begin
            // bytes 0 and 1 of each triple trade places, a lone trailing byte stays
            case (pkt_pos % 3)
              0: dest = (pkt_pos + 1 < pkt_len) ? pkt_pos + 1 : pkt_pos;
              1: dest = pkt_pos - 1;
              default: dest = pkt_pos;
            endcase
            if (dest < lsut_pkg::STRAND_BYTES)
              strand_mem[pkt_strand * lsut_pkg::STRAND_BYTES + dest] = it.bval;
            pkt_pos++;
          end
        end
        default: ;
      endcase
      if (it.pend) parse_pos = lsut_pkg::HDR_CMD;
    end
    if (run.size() > 0) begin
      ob = run.pop_back();
      ob.last = 1'b1;
      run.push_back(ob);
    end
    foreach (run[i]) planned.push_back(run[i]);
  endfunction

  // input side: accepted beats feed the model, config writes update the selection
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_beats(in_cur);
      in_taken = 1'b1;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == lsut_pkg::REG_FIRST) sel_first = cfg_data;
      else sel_last = cfg_data;
    end
  end

  // input driver: random gap before each beat, valid held until taken
  always @(negedge clk) begin
    in_beat_t nxt;
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        nxt = pending.pop_front();
        in_cur = nxt;
        in_tdata <= {5'b0, nxt.pidx, nxt.bval};
        in_tuser <= nxt.asm_req;
        in_tlast <= nxt.pend;
        in_tvalid <= 1'b1;
        in_wait = $urandom_range(0, in_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor: compare each beat against the oldest planned one
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (planned.size() == 0) begin
        $error("unexpected result beat: kind %0d out_byte %0d run_last %0d",
               out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        want = planned.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata !== want.value) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.value, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, out_tlast);
          errors++;
        end
      end
      beats_seen++;
      if (beats_seen == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
      out_wait = $urandom_range(0, out_gap_max);
    end
  end

  // result receiver: per-beat stall plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void queue_beat(input logic asm_req, input logic [7:0] bval,
                                     input logic pend, input logic [10:0] pidx);
    pending.push_back(in_beat_t'{asm_req, bval, pend, pidx});
    queued++;
  endfunction

  function automatic void queue_byte(input logic [7:0] bval, input logic pend);
    queue_beat(1'b0, bval, pend, 11'($urandom));
  endfunction

  // an index is safe unless some selected strand holds it inside an unwritten stretch
  function automatic bit index_readable(input int unsigned idx);
    int unsigned st;
    for (int s = 0; s < lsut_pkg::LANES; s++) begin
      st = sel_first + s;
      if (st <= sel_last && st < lsut_pkg::NUM_STRANDS && idx < len_seen[st] &&
          idx >= filled_upto[st])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void queue_assemble();
    int unsigned idx;
    int unsigned st;
    for (int tries = 0; tries < 16; tries++) begin
      st = sel_first + $urandom_range(0, lsut_pkg::LANES - 1);
      case ($urandom_range(0, 4))
        0: idx = 0;
        1, 2: idx = (st < lsut_pkg::NUM_STRANDS && filled_upto[st] > 0) ?
                    $urandom_range(0, filled_upto[st] - 1) : $urandom_range(0, 7);
        default: idx = $urandom_range(0, (1 << lsut_pkg::IDX_W) - 1);
      endcase
      if (index_readable(idx)) begin
        queue_beat(1'b1, 8'($urandom), 1'($urandom), 11'(idx));
        return;
      end
    end
  endfunction

  // strand packet: header, then sent payload bytes, packet end on the final byte
  function automatic void queue_strand_pkt(input logic [7:0] strand, input int unsigned plen,
                                           input int unsigned sent, input bit mix);
    bit take;
    take = strand_in_range(strand);
    queue_byte(lsut_pkg::CHAR_STRAND, 1'b0);
    queue_byte(strand, 1'b0);
    queue_byte(plen[7:0], 1'b0);
    queue_byte(plen[15:8], sent == 0);
    if (take)
      len_seen[strand] = (plen < lsut_pkg::STRAND_BYTES) ? plen : lsut_pkg::STRAND_BYTES;
    for (int unsigned i = 0; i < sent; i++) begin
      if (mix && $urandom_range(0, 5) == 0) queue_assemble();
      queue_byte(8'($urandom), i == sent - 1);
    end
    if (take && sent >= plen && len_seen[strand] > filled_upto[strand])
      filled_upto[strand] = len_seen[strand];
  endfunction

  // begin or end packet, possibly with trailing bytes that get skipped
  function automatic void queue_event_pkt();
    int unsigned extra;
    extra = $urandom_range(0, 2);
    queue_byte($urandom_range(0, 1) ? lsut_pkg::CHAR_BEGIN : lsut_pkg::CHAR_END, extra == 0);
    for (int unsigned i = 0; i < extra; i++) queue_byte(8'($urandom), i == extra - 1);
  endfunction

  // packet with a random non-strand command or a strand header cut short
  function automatic void queue_broken_pkt();
    logic [7:0]  cmd;
    int unsigned cnt;
    if ($urandom_range(0, 1)) begin
      cnt = $urandom_range(0, 2);
      queue_byte(lsut_pkg::CHAR_STRAND, cnt == 0);
      for (int unsigned i = 0; i < cnt; i++) queue_byte(8'($urandom), i == cnt - 1);
    end else begin
      do cmd = 8'($urandom); while (cmd == lsut_pkg::CHAR_STRAND);
      cnt = $urandom_range(0, 3);
      queue_byte(cmd, cnt == 0);
      for (int unsigned i = 0; i < cnt; i++) queue_byte(8'($urandom), i == cnt - 1);
    end
  endfunction

  task automatic random_phase(input int unsigned n);
    logic [7:0]  strand;
    int unsigned plen;
    int unsigned sent;
    queued = 0;
    while (queued < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // well-formed strand packet, mostly to a selected strand
          strand = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                   8'(sel_first + $urandom_range(0, lsut_pkg::LANES - 1));
          plen = $urandom_range(0, 10);
          sent = plen + (($urandom_range(0, 5) == 0) ? 1 : 0);
          queue_strand_pkt(strand, plen, sent, $urandom_range(0, 2) == 0);
        end
        4: begin
          // payload ended early, sometimes with a huge declared length
          strand = 8'(sel_first + $urandom_range(0, lsut_pkg::LANES - 1));
          plen = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16'hFFFF)
                                               : $urandom_range(2, 12);
          sent = $urandom_range(0, (plen < 4) ? plen : 4);
          queue_strand_pkt(strand, plen, sent, 1'b0);
        end
        5, 6, 7: queue_assemble();
        8: queue_event_pkt();
        default: queue_broken_pkt();
      endcase
    end
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every beat is taken and every planned result has arrived
  task automatic wait_idle();
    int unsigned n;
    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    n = 0;
    while (planned.size() != 0 && n < MISS_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (planned.size() != 0) begin
      $error("%0d result beats never arrived", planned.size());
      errors++;
      planned.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    logic [3:0] f;
    logic [3:0] l;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: events, unknown command, swapped payload with odd tail, rejected strand
    queued = 0;
    queue_byte(lsut_pkg::CHAR_BEGIN, 1'b1);
    queue_byte(lsut_pkg::CHAR_END, 1'b0);
    queue_byte(lsut_pkg::CHAR_STRAND, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_strand_pkt(8'd0, 5, 6, 1'b0);
    queue_strand_pkt(8'd9, 1, 1, 1'b0);
    queue_beat(1'b1, 8'hFF, 1'b1, 11'd0);
    queue_beat(1'b1, 8'h00, 1'b0, 11'd4);
    queue_beat(1'b1, 8'h5A, 1'b1, 11'd5);
    queue_beat(1'b1, 8'hA5, 1'b0, 11'h7FF);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin f = 4'd0;  l = 4'd15; end
        1: begin f = 4'd8;  l = 4'd15; end
        2: begin f = 4'd15; l = 4'd15; end
        3: begin f = 4'd5;  l = 4'd2;  end
        4: begin f = 4'd0;  l = 4'd0;  end
        5: begin f = 4'd15; l = 4'd0;  end
        6: begin f = 4'd3;  l = 4'd12; end
        default: begin f = 4'($urandom); l = 4'($urandom); end
      endcase
      write_reg(lsut_pkg::REG_FIRST, f);
      write_reg(lsut_pkg::REG_LAST, l);
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      random_phase(PHASE_BEATS);
      wait_idle();
    end

    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

### files.f
rtl/core/lsut_pkg.sv
rtl/core/lsut_fifo.sv
rtl/core/lsut_front.sv
rtl/core/lsut_back.sv
rtl/core/led_strand_unpack_and_bit_transpose.sv
tb/tb_top.sv
